// ===== rtl/brbf_pkg.sv =====
// Shared types and constants of the batch-read byte FIFO.
package brbf_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned DataW           = 8;
  localparam int unsigned BatchW          = 4;
  localparam int unsigned MaxBatch        = 9;
  localparam int unsigned ApbDataW        = 32;
  localparam int unsigned ApbAddrW        = 2;

  localparam logic [ApbAddrW-1:0] RegAddrBatchCount = ApbAddrW'(0);
  localparam logic [BatchW-1:0]   BatchCountReset   = BatchW'(1);

  // Operation requested by an input transaction.
  localparam logic FuncPush = 1'b0;
  localparam logic FuncPop  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SHORT = 2'd3
  } brbf_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         wr_en;
    logic         out_load;
    logic         out_from_ram;
    brbf_status_e out_status;
    logic         out_last;
    logic         rem_load;
    logic         rem_dec;
    logic         head_adv;
  } brbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic short_fill;
    logic rem_last;
    logic out_free;
  } brbf_sts_t;

endpackage

// ===== rtl/brbf_in_if.sv =====
// Input channel: operation and byte, valid/ready handshake.
interface brbf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [brbf_pkg::DataW-1:0]  value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

// ===== rtl/brbf_out_if.sv =====
// Output channel: popped byte with status and last marker, valid/ready handshake.
interface brbf_out_if;
  logic                        valid;
  logic                        ready;
  logic [brbf_pkg::DataW-1:0]  data_out;
  logic [1:0]                  status;
  logic                        last;

  modport source (output valid, data_out, status, last, input ready);
  modport sink   (input valid, data_out, status, last, output ready);
endinterface

// ===== rtl/brbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/brbf_datapath.sv =====
// Datapath: storage, pointers, batch counter, output register and config register.
module brbf_datapath #(
  parameter int unsigned Depth = brbf_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brbf_pkg::brbf_cmd_t             cmd_i,
  output brbf_pkg::brbf_sts_t             sts_o,
  input  logic [brbf_pkg::DataW-1:0]      value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [brbf_pkg::DataW-1:0]      out_data_o,
  output logic [1:0]                      out_status_o,
  output logic                            out_last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brbf_pkg::ApbAddrW-1:0]   paddr,
  input  logic [brbf_pkg::ApbDataW-1:0]   pwdata,
  output logic [brbf_pkg::ApbDataW-1:0]   prdata
);
  import brbf_pkg::*;

  localparam int unsigned AW   = $clog2(Depth);
  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned SumW = AW + 1;
  localparam int unsigned CmpW = (CW > BatchW) ? CW : BatchW;

  logic [AW-1:0]     head_q, head_d, head_inc, tail;
  logic [CW-1:0]     count_q, count_d;
  logic [SumW-1:0]   tail_sum;
  logic [BatchW-1:0] bc_q, bc_d, batch_n, rem_q, rem_d;
  logic [DataW-1:0]  rdata;
  logic              out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [DataW-1:0]  out_data_q, out_data_d;
  brbf_status_e      out_status_q, out_status_d;
  logic              cfg_wr;

  // Effective batch length: zero acts as one, large values saturate.
  always_comb begin
    if (bc_q == '0) begin
      batch_n = BatchW'(1);
    end else if (bc_q > BatchW'(MaxBatch)) begin
      batch_n = BatchW'(MaxBatch);
    end else begin
      batch_n = bc_q;
    end
  end

  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(Depth)) ? AW'(tail_sum - SumW'(Depth)) : AW'(tail_sum);
  assign head_inc = (head_q == AW'(Depth - 1)) ? '0 : head_q + AW'(1);
  assign head_d   = cmd_i.head_adv ? head_inc : head_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.head_adv) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.rem_load) begin
      rem_d = batch_n;
    end else if (cmd_i.rem_dec) begin
      rem_d = rem_q - BatchW'(1);
    end
  end

  // Read at the next head so the oldest byte is ready in the next cycle.
  brbf_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (tail),
    .wdata_i (value_i),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  assign sts_o.full       = (count_q == CW'(Depth));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.short_fill = (CmpW'(count_q) < CmpW'(batch_n));
  assign sts_o.rem_last   = (rem_q == BatchW'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = cmd_i.out_from_ram ? rdata : '0;
      out_status_d = cmd_i.out_status;
      out_last_d   = cmd_i.out_last;
    end else if (out_ready_i) begin
      out_valid_d  = 1'b0;
    end
  end

  assign cfg_wr = psel && penable && pwrite && (paddr == RegAddrBatchCount);
  assign bc_d   = cfg_wr ? pwdata[BatchW-1:0] : bc_q;
  assign prdata = (paddr == RegAddrBatchCount) ? ApbDataW'(bc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      bc_q        <= BatchCountReset;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      bc_q        <= bc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(Depth))
    else $error("fill count beyond depth");
  a_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    SumW'(head_q) < SumW'(Depth))
    else $error("head index beyond depth");
  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (count_q != CW'(Depth)))
    else $error("write into a full store");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.head_adv |-> (count_q != '0))
    else $error("pop from an empty store");
  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.head_adv |=> (count_q == $past(count_q) - CW'(1)))
    else $error("fill count not reduced by a popped byte");
`endif

endmodule

// ===== rtl/brbf_ctrl.sv =====
// Controller: accepts transactions and sequences batch reads.
module brbf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  brbf_pkg::brbf_sts_t sts_i,
  output brbf_pkg::brbf_cmd_t cmd_o
);
  import brbf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (accept) begin
          if (func_i == FuncPush) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.wr_en      = !sts_i.full;
            cmd_o.out_status = sts_i.full ? ST_FULL : ST_OK;
          end else if (sts_i.empty) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.out_status = ST_EMPTY;
          end else if (sts_i.short_fill) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.out_status = ST_SHORT;
          end else begin
            cmd_o.rem_load = 1'b1;
            state_d        = S_POP;
          end
        end
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_ram = 1'b1;
          cmd_o.out_last     = sts_i.rem_last;
          cmd_o.head_adv     = 1'b1;
          cmd_o.rem_dec      = 1'b1;
          if (sts_i.rem_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> !in_ready_o)
    else $error("transaction taken during a batch read");
  a_pop_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_POP) |-> (!sts_i.empty && !sts_i.short_fill))
    else $error("batch read started without enough bytes");
  a_batch_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP && cmd_o.out_last) |=> (state_q == S_IDLE))
    else $error("batch read did not end after its last byte");
`endif

endmodule

// ===== rtl/batch_read_byte_fifo_unit.sv =====
// Top level of the batch-read byte FIFO: controller, datapath and register port.
//
//   channel   direction  handshake              payload
//   in_i      sink       valid/ready            func, value
//   out_o     source     valid/ready            data_out, status, last
//   apb       slave      psel/penable, pready=1 paddr, pwdata, prdata
//
// A push transaction yields one result; pushes can follow
// back to back while the output register drains.
// A successful pop fetches the oldest byte through the registered RAM read, then
// yields N results (N = batch_count, zero read as one, capped at nine) back to
// back unless the output stalls, and no input is taken until the batch ends.
// Empty or short pops yield one status result.
// A stalled output register holds its transaction and stops both push intake
// and batch reads; the next input is still taken in the cycle the sink drains it.
// Reset clears pointers, fill count and batch_count (to one); no RAM clearing.
module batch_read_byte_fifo_unit #(
  parameter int unsigned DEPTH = brbf_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  brbf_in_if.sink                         in_i,
  brbf_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brbf_pkg::ApbAddrW-1:0]   paddr,
  input  logic [brbf_pkg::ApbDataW-1:0]   pwdata,
  output logic [brbf_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import brbf_pkg::*;

  brbf_cmd_t cmd;
  brbf_sts_t sts;

  // Register port never stalls.
  assign pready = 1'b1;

  brbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .func_i     (in_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brbf_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (in_i.value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_data_o   (out_o.data_out),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

`ifndef SYNTHESIS
  a_push_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.func == FuncPush) |=> (out_o.valid && out_o.last))
    else $error("push transaction without a single final result");
  a_status_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> (out_o.data_out == '0 && out_o.last))
    else $error("status-only result carries data or is not final");
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the output register is stalled");
`endif

endmodule
